// ----- hw/rtl/plt_pkg.sv -----
// Package for the piecewise linear table interpolator: word types, function
// codes and the fixed datapath widths. No dependencies; every other file of
// the block imports it.
package plt_pkg;

  // Function codes of an input word.
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam int COUNT_W = 10;   // entry_count register
  localparam int INDEX_W = 9;    // entry_index field
  localparam int BP_W    = 16;   // integer breakpoint
  localparam int VAL_W   = 32;   // Q16.16 value and point
  localparam int FRAC_W  = 16;   // fraction bits of Q16.16

  // Multiplier: 33-bit magnitude times 33-bit magnitude, two 17-bit digits.
  localparam int MUL_A_W     = 33;
  localparam int MUL_DIGIT_W = 17;
  localparam int MUL_DIGITS  = 2;
  localparam int MUL_B_W     = MUL_DIGIT_W * MUL_DIGITS;
  localparam int PP_W        = MUL_A_W + MUL_DIGIT_W;
  localparam int PROD_W      = 66;

  // Divider: product without its fraction bits over the breakpoint span.
  localparam int DIVIDEND_W = 49;
  localparam int DIVISOR_W  = 16;
  localparam int DIV_CNT_W  = 6;

  // Signed result before saturation.
  localparam int RES_W = 50;
  localparam logic signed [RES_W-1:0] RES_MAX = RES_W'(32'h7fff_ffff);
  localparam logic signed [RES_W-1:0] RES_MIN = -RES_MAX - RES_W'(1);

  typedef struct packed {
    logic                    func;
    logic [INDEX_W-1:0]      entry_index;
    logic signed [BP_W-1:0]  entry_breakpoint;
    logic signed [VAL_W-1:0] entry_value;
    logic signed [VAL_W-1:0] query_point;
  } plt_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] interp_value;
    logic                    saturated;
  } plt_out_t;

  // One table entry as held in the memories.
  typedef struct packed {
    logic signed [BP_W-1:0]  bp;
    logic signed [VAL_W-1:0] val;
  } plt_entry_t;

endpackage

// ----- hw/rtl/plt_table.sv -----
// Breakpoint and value memories of the interpolator: one write port, one
// read port with a registered read output. Depends on plt_pkg.
module plt_table import plt_pkg::*; #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  plt_entry_t    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output plt_entry_t    rd_data
);

  logic signed [BP_W-1:0]  bp_mem  [DEPTH];
  logic signed [VAL_W-1:0] val_mem [DEPTH];
  plt_entry_t              rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bp_mem[wr_addr]  <= wr_data.bp;
      val_mem[wr_addr] <= wr_data.val;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r.bp  <= bp_mem[rd_addr];
      rd_data_r.val <= val_mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hw/rtl/plt_mul.sv -----
// Digit-serial unsigned multiplier of the interpolator: one 33 x 17 partial
// product per cycle, registered, then accumulated. Depends on plt_pkg.
module plt_mul import plt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_A_W-1:0] b,
  output logic               done,
  output logic [PROD_W-1:0]  product
);

  localparam int STEP_W = (MUL_DIGITS > 1) ? $clog2(MUL_DIGITS) : 1;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MUL_DIGITS - 1);

  logic                   busy_r;
  logic                   pp_vld_r;
  logic                   done_r;
  logic [STEP_W-1:0]      step_r;
  logic [STEP_W-1:0]      pp_sh_r;
  logic [PP_W-1:0]        pp_r;
  logic [PROD_W-1:0]      acc_r;
  logic [MUL_B_W-1:0]     b_ext;
  logic [MUL_DIGIT_W-1:0] digit;

  assign b_ext = MUL_B_W'(b);
  assign digit = b_ext[MUL_DIGIT_W*step_r +: MUL_DIGIT_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      pp_vld_r <= 1'b0;
      done_r   <= 1'b0;
      step_r   <= '0;
    end else begin
      done_r   <= pp_vld_r && (pp_sh_r == STEP_LAST);
      pp_vld_r <= busy_r;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_LAST) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      pp_r    <= a * digit;
      pp_sh_r <= step_r;
    end
    if (start) begin
      acc_r <= '0;
    end else if (pp_vld_r) begin
      acc_r <= acc_r + (PROD_W'(pp_r) << (MUL_DIGIT_W * pp_sh_r));
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

// ----- hw/rtl/plt_div.sv -----
// Restoring divider of the interpolator: one quotient bit per cycle, the
// quotient shifts into the dividend register. Depends on plt_pkg.
module plt_div import plt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIVIDEND_W - 1);

  logic                  busy_r;
  logic                  done_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic [DIVIDEND_W-1:0] work_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVISOR_W-1:0]  rem_nxt;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  // The remainder stays below the divisor, so the trial value has one bit more.
  assign trial   = {rem_r, work_r[DIVIDEND_W-1]};
  assign fits    = trial >= {1'b0, divisor};
  assign rem_nxt = fits ? DIVISOR_W'(trial - {1'b0, divisor}) : trial[DIVISOR_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_LAST);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + DIV_CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work_r <= dividend;
      rem_r  <= '0;
    end else if (busy_r) begin
      work_r <= {work_r[DIVIDEND_W-2:0], fits};
      rem_r  <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = work_r;

endmodule

// ----- hw/rtl/piecewise_linear_table_interp.sv -----
// Top level of the piecewise linear table interpolator: sequencer, bracket
// scan and result stage. Depends on plt_pkg, plt_table, plt_mul and plt_div.
//
// Usage. Input words arrive on in_valid/in_ready/in_data. A word with func set
// to write stores one breakpoint and its Q16.16 value at entry_index; it is
// taken from the idle state and gives no result, so a stream of writes loads the
// table at one word per cycle. Indexes at or beyond TABLE_DEPTH are dropped.
// A word with func set to query interpolates at query_point and gives one
// result word on out_valid/out_ready/out_data, clipped to 32 bits with the
// saturated flag set when clipping happened.
// Sequence. A query first runs the bracket scan over the n entries in use,
// where n is the clamped entry count: the bracket scan reads one breakpoint
// per cycle from the single memory read port, and the 49-bit restoring
// divider then takes one quotient bit per cycle. When the bracketing pair has
// equal breakpoints the multiply and divide are skipped.
// One word is worked on at a time; in_ready is high whenever no query is in
// progress, even while a finished result waits at the output register.
// Stalls. If the receiver holds out_ready low, the result stays in the output
// register, and a second query finishes its arithmetic and then waits until
// that register is free.
// Reset. rst_n clears control state and sets entry_count to 2; the table
// contents are undefined until written. cfg_wr_en/cfg_wr_data write the entry
// count, which the user must write only while the block is idle; not enforced.
module piecewise_linear_table_interp import plt_pkg::*; #(
  parameter int TABLE_DEPTH = 512
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  plt_in_t            in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output plt_out_t           out_data,
  input  logic               cfg_wr_en,
  input  logic [COUNT_W-1:0] cfg_wr_data
);

  localparam int AW = $clog2(TABLE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_PICK,
    S_RDLO,
    S_RDHI,
    S_PREP,
    S_MUL,
    S_DIV,
    S_ADD,
    S_OUT
  } state_t;

  state_t state_r;

  // Configuration.
  logic [COUNT_W-1:0] entry_count_r;

  // Query context.
  logic signed [VAL_W-1:0] d_r;
  logic [AW-1:0]           last_idx_r;
  logic [AW-1:0]           scan_r;
  logic                    chk_vld_r;
  logic [AW-1:0]           chk_idx_r;

  // Scan results.
  logic          below0_r;
  logic          above_r;
  logic          fgt_found_r;
  logic [AW-1:0] fgt_idx_r;
  logic          llt_found_r;
  logic [AW-1:0] llt_idx_r;
  logic [AW-1:0] hi_r;

  // Arithmetic operands.
  logic signed [BP_W-1:0]  b1_r;
  logic signed [BP_W-1:0]  b2_r;
  logic signed [VAL_W-1:0] e1_r;
  logic signed [VAL_W-1:0] e2_r;
  logic [MUL_A_W-1:0]      m1_r;
  logic [MUL_A_W-1:0]      m2_r;
  logic [DIVISOR_W-1:0]    dv_r;
  logic                    neg_r;
  logic signed [RES_W-1:0] res_r;
  logic                    mul_start_r;
  logic                    div_start_r;

  // Output register.
  logic     out_valid_r;
  plt_out_t out_data_r;

  // Memory port.
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  plt_entry_t    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  plt_entry_t    mem_rdata;

  // Combinational helpers.
  logic                    accept;
  logic                    idx_ok;
  logic [31:0]             n_use;
  logic [AW-1:0]           last_sel;
  logic signed [VAL_W-1:0] bp_x;
  logic                    d_lt_bp;
  logic                    d_gt_bp;
  logic [AW-1:0]           lo_idx;
  logic [AW-1:0]           hi_idx;
  logic signed [VAL_W-1:0] b1_x;
  logic signed [MUL_A_W-1:0] diff_e;
  logic signed [MUL_A_W-1:0] diff_d;
  logic signed [BP_W:0]      diff_b;
  logic [MUL_A_W-1:0]        m1_nxt;
  logic [MUL_A_W-1:0]        m2_nxt;
  logic [BP_W:0]             dv_nxt;
  logic                      mul_done;
  logic [PROD_W-1:0]         product;
  logic                      div_done;
  logic [DIVIDEND_W-1:0]     quotient;
  logic signed [RES_W-1:0]   q_s;
  logic                      sat_hi;
  logic                      sat_lo;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Entry count in use, clamped to [2, TABLE_DEPTH].
  always_comb begin
    if (entry_count_r < COUNT_W'(2)) begin
      n_use = 32'd2;
    end else if (32'(entry_count_r) > 32'(TABLE_DEPTH)) begin
      n_use = 32'(TABLE_DEPTH);
    end else begin
      n_use = 32'(entry_count_r);
    end
  end
  assign last_sel = AW'(n_use - 32'd1);

  // Write words go straight into the table from the idle state.
  assign idx_ok        = 32'(in_data.entry_index) < 32'(TABLE_DEPTH);
  assign mem_we        = accept && (in_data.func == FUNC_WRITE) && idx_ok;
  assign mem_waddr     = AW'(in_data.entry_index);
  assign mem_wdata.bp  = in_data.entry_breakpoint;
  assign mem_wdata.val = in_data.entry_value;

  // Reads: the whole active table during the scan, then the lower and the
  // upper entry of the bracketing pair.
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = '0;
    case (state_r)
      S_SCAN: begin
        mem_re    = 1'b1;
        mem_raddr = scan_r;
      end
      S_PICK: begin
        mem_re    = 1'b1;
        mem_raddr = lo_idx;
      end
      S_RDLO: begin
        mem_re    = 1'b1;
        mem_raddr = hi_r;
      end
      default: begin
        mem_re    = 1'b0;
        mem_raddr = '0;
      end
    endcase
  end

  plt_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // A breakpoint counts as an integer in Q16.16, so it fills a 32-bit word.
  assign bp_x    = $signed({mem_rdata.bp, {FRAC_W{1'b0}}});
  assign d_lt_bp = d_r < bp_x;
  assign d_gt_bp = d_r > bp_x;

  // Bracketing pair. Below the first breakpoint the first two entries are
  // used, above the last the final two. Otherwise the lower entry sits just
  // before the first breakpoint above the point and the upper entry just
  // after the last breakpoint below it; a point on a breakpoint selects that
  // entry for both.
  always_comb begin
    if (below0_r) begin
      lo_idx = '0;
      hi_idx = AW'(1);
    end else if (above_r) begin
      lo_idx = last_idx_r - AW'(1);
      hi_idx = last_idx_r;
    end else begin
      lo_idx = fgt_found_r ? fgt_idx_r - AW'(1) : last_idx_r;
      hi_idx = llt_found_r ? llt_idx_r + AW'(1) : '0;
    end
  end

  // Signed differences and their magnitudes for the slope term.
  assign b1_x   = $signed({b1_r, {FRAC_W{1'b0}}});
  assign diff_e = MUL_A_W'(e2_r) - MUL_A_W'(e1_r);
  assign diff_d = MUL_A_W'(d_r) - MUL_A_W'(b1_x);
  assign diff_b = (BP_W + 1)'(b2_r) - (BP_W + 1)'(b1_r);
  assign m1_nxt = diff_e[MUL_A_W-1] ? MUL_A_W'(-diff_e) : MUL_A_W'(diff_e);
  assign m2_nxt = diff_d[MUL_A_W-1] ? MUL_A_W'(-diff_d) : MUL_A_W'(diff_d);
  assign dv_nxt = diff_b[BP_W] ? (BP_W + 1)'(-diff_b) : (BP_W + 1)'(diff_b);

  plt_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start_r),
    .a       (m1_r),
    .b       (m2_r),
    .done    (mul_done),
    .product (product)
  );

  // The span is a whole number times 2^16, so the fraction bits of the
  // product drop out before the division without changing the quotient.
  plt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (product[DIVIDEND_W+FRAC_W-1:FRAC_W]),
    .divisor  (dv_r),
    .done     (div_done),
    .quotient (quotient)
  );

  assign q_s    = $signed(RES_W'(quotient));
  assign sat_hi = res_r > RES_MAX;
  assign sat_lo = res_r < RES_MIN;

  // Control, scan flags and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      entry_count_r <= COUNT_W'(2);
      chk_vld_r     <= 1'b0;
      mul_start_r   <= 1'b0;
      div_start_r   <= 1'b0;
      out_valid_r   <= 1'b0;
      below0_r      <= 1'b0;
      above_r       <= 1'b0;
      fgt_found_r   <= 1'b0;
      llt_found_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        entry_count_r <= cfg_wr_data;
      end
      chk_vld_r   <= (state_r == S_SCAN);
      mul_start_r <= 1'b0;
      div_start_r <= 1'b0;
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      // Breakpoint data returns in the cycle after its read.
      if (chk_vld_r) begin
        if (chk_idx_r == '0) begin
          below0_r <= d_lt_bp;
        end
        if (chk_idx_r == last_idx_r) begin
          above_r <= d_gt_bp;
        end
        if (d_lt_bp && !fgt_found_r) begin
          fgt_found_r <= 1'b1;
        end
        if (d_gt_bp) begin
          llt_found_r <= 1'b1;
        end
      end

      case (state_r)
        S_IDLE: begin
          if (accept && (in_data.func == FUNC_QUERY)) begin
            below0_r    <= 1'b0;
            above_r     <= 1'b0;
            fgt_found_r <= 1'b0;
            llt_found_r <= 1'b0;
            state_r     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_r == last_idx_r) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: state_r <= S_PICK;
        S_PICK:  state_r <= S_RDLO;
        S_RDLO:  state_r <= S_RDHI;
        S_RDHI:  state_r <= S_PREP;
        S_PREP: begin
          if (b1_r == b2_r) begin
            state_r <= S_OUT;
          end else begin
            mul_start_r <= 1'b1;
            state_r     <= S_MUL;
          end
        end
        S_MUL: begin
          if (mul_done) begin
            div_start_r <= 1'b1;
            state_r     <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_ADD;
          end
        end
        S_ADD: state_r <= S_OUT;
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept && (in_data.func == FUNC_QUERY)) begin
      d_r        <= in_data.query_point;
      last_idx_r <= last_sel;
      scan_r     <= '0;
    end else if (state_r == S_SCAN) begin
      scan_r <= scan_r + AW'(1);
    end
    chk_idx_r <= scan_r;

    if (chk_vld_r) begin
      if (d_lt_bp && !fgt_found_r) begin
        fgt_idx_r <= chk_idx_r;
      end
      if (d_gt_bp) begin
        llt_idx_r <= chk_idx_r;
      end
    end

    if (state_r == S_PICK) begin
      hi_r <= hi_idx;
    end
    if (state_r == S_RDLO) begin
      b1_r <= mem_rdata.bp;
      e1_r <= mem_rdata.val;
    end
    if (state_r == S_RDHI) begin
      b2_r <= mem_rdata.bp;
      e2_r <= mem_rdata.val;
    end
    if (state_r == S_PREP) begin
      m1_r  <= m1_nxt;
      m2_r  <= m2_nxt;
      dv_r  <= dv_nxt[DIVISOR_W-1:0];
      neg_r <= (diff_e[MUL_A_W-1] ^ diff_d[MUL_A_W-1]) ^ diff_b[BP_W];
      res_r <= RES_W'(e1_r);
    end
    if (state_r == S_ADD) begin
      res_r <= neg_r ? RES_W'(e1_r) - q_s : RES_W'(e1_r) + q_s;
    end
    if ((state_r == S_OUT) && (!out_valid_r || out_ready)) begin
      out_data_r.saturated <= sat_hi || sat_lo;
      if (sat_hi) begin
        out_data_r.interp_value <= RES_MAX[VAL_W-1:0];
      end else if (sat_lo) begin
        out_data_r.interp_value <= RES_MIN[VAL_W-1:0];
      end else begin
        out_data_r.interp_value <= res_r[VAL_W-1:0];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The bracketing pair always lies inside the active part of the table.
  a_pair_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PICK) |-> (lo_idx <= last_idx_r) && (hi_idx <= last_idx_r))
    else $error("bracketing pair outside the active table");

  // A write word and a table read never share a cycle.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("table write and read in the same cycle");

  // A new result is loaded only from the result stage.
  a_out_from_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result word raised outside the result stage");

  // Multiplier and divider are never started together.
  a_one_unit_start: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_start_r && div_start_r))
    else $error("multiplier and divider started together");

endmodule

// ----- verif/tb_piecewise_linear_table_interp.sv -----
// Self-checking testbench for piecewise_linear_table_interp: loads breakpoint tables,
// queries points on, between and beyond them, and checks each result word.
// Depends on plt_pkg and the block's RTL only.
module tb_piecewise_linear_table_interp;
  timeunit 1ns;
  timeprecision 1ps;
  import plt_pkg::*;

  localparam int     TABLE_DEPTH       = 512;
  localparam int     TOTAL_ITEMS       = 1040;  // stimulus stops once this many are queued
  localparam int     PHASE_ITEMS       = 40;    // random words per freshly loaded table
  localparam int     LONG_HOLD_CYCLES  = 400;   // receiver back-pressure stretch
  localparam int     RESULT_WAIT_LIMIT = 5000;  // well above two queries at full depth
  localparam int     SETTLE_CYCLES     = 8;     // a write lands in the table at the edge that accepts it
  localparam int     FINAL_CYCLES      = 600;   // about one full-depth query
  localparam longint VAL_MAX           = 64'sd2147483647;
  localparam longint VAL_MIN           = -64'sd2147483648;

  // Block ports. Every input has a known value from time zero.
  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               in_valid    = 1'b0;
  logic               in_ready;
  plt_in_t            in_data     = '0;
  logic               out_valid;
  logic               out_ready   = 1'b0;
  plt_out_t           out_data;
  logic               cfg_wr_en   = 1'b0;
  logic [COUNT_W-1:0] cfg_wr_data = '0;

  // Stimulus side: words waiting for the driver, and the table as it will
  // stand once those words are taken. The query generator aims at it.
  plt_in_t                 pending_words[$];
  logic signed [BP_W-1:0]  plan_bp[TABLE_DEPTH];
  int                      items_pushed = 0;

  // Predictor state, updated in acceptance order by the monitor (the entry count by write_entry_count).
  logic signed [BP_W-1:0]  shadow_bp[TABLE_DEPTH];
  logic signed [VAL_W-1:0] shadow_val[TABLE_DEPTH];
  logic [COUNT_W-1:0]      shadow_count = COUNT_W'(2);
  plt_out_t                expected_interp_q[$];
  plt_out_t                want_word;

  // Handshake bookkeeping shared between the clocked processes.
  bit in_accepted   = 1'b0;  // set at the rising edge, read at the falling edge
  bit idle_enable   = 1'b1;  // random gaps allowed on both sides
  bit sink_hold     = 1'b0;  // long receiver hold-off in progress
  int src_gap_left  = 0;
  int sink_gap_left = 0;

  int items_accepted  = 0;
  int writes_taken    = 0;
  int queries_taken   = 0;
  int results_checked = 0;
  int counts_applied  = 0;
  int error_count     = 0;

  piecewise_linear_table_interp #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial forever #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  // The block treats an entry count below two as two and one above the
  // table depth as the full depth.
  function automatic int clamp_count(input logic [COUNT_W-1:0] value);
    if (value < 2) return 2;
    if (value > TABLE_DEPTH) return TABLE_DEPTH;
    return int'(value);
  endfunction

  // Breakpoint k of the predictor's table, moved into Q16.16.
  function automatic longint scaled_bp(input int k);
    return longint'(shadow_bp[k]) * 65536;
  endfunction

  // Expected result word for a query at the given Q16.16 point.
  function automatic plt_out_t predict_interp(input logic signed [VAL_W-1:0] point);
    int           n, lo_i, hi_i, k;
    longint       d, b1, b2, e1, e2, dv, dp, ds, res;
    logic [127:0] quo;
    bit           flip;
    plt_out_t     r;
    n = clamp_count(shadow_count);
    d = point;
    // Outside the table the end pair is used for extrapolation. Inside it
    // the lower entry comes from an upward scan and the upper one from a
    // downward scan, so a point on a breakpoint brackets that entry twice.
    if (d < scaled_bp(0)) begin
      lo_i = 0;
      hi_i = 1;
    end else if (d > scaled_bp(n - 1)) begin
      lo_i = n - 2;
      hi_i = n - 1;
    end else begin
      k = 0;
      while (k < n && d >= scaled_bp(k)) k++;
      lo_i = (k == 0) ? 0 : k - 1;
      k = n - 1;
      while (k >= 0 && d <= scaled_bp(k)) k--;
      hi_i = k + 1;
    end
    b1 = scaled_bp(lo_i);
    b2 = scaled_bp(hi_i);
    e1 = shadow_val[lo_i];
    e2 = shadow_val[hi_i];
    if (b1 == b2) begin
      res = e1;
    end else begin
      // Exact product over the span, truncated toward zero.
      dv   = e2 - e1;
      dp   = d - b1;
      ds   = b2 - b1;
      flip = ((dv < 0) != (dp < 0)) != (ds < 0);
      quo  = (128'(dv < 0 ? -dv : dv) * 128'(dp < 0 ? -dp : dp)) / 128'(ds < 0 ? -ds : ds);
      if (quo > (128'd1 << 60)) quo = 128'd1 << 60;
      res = flip ? e1 - longint'(quo[62:0]) : e1 + longint'(quo[62:0]);
    end
    r.saturated = 1'b0;
    if (res > VAL_MAX) begin
      res = VAL_MAX;
      r.saturated = 1'b1;
    end else if (res < VAL_MIN) begin
      res = VAL_MIN;
      r.saturated = 1'b1;
    end
    r.interp_value = res[VAL_W-1:0];
    return r;
  endfunction

  task automatic queue_word(input plt_in_t w);
    pending_words.push_back(w);
    items_pushed++;
    if (w.func == FUNC_WRITE) plan_bp[w.entry_index] = w.entry_breakpoint;
  endtask

  // A write carries a random query point, which the block must ignore.
  task automatic queue_table_write(input logic [INDEX_W-1:0] idx,
                                   input logic signed [BP_W-1:0] bp,
                                   input logic signed [VAL_W-1:0] val);
    plt_in_t w;
    w.func             = FUNC_WRITE;
    w.entry_index      = idx;
    w.entry_breakpoint = bp;
    w.entry_value      = val;
    w.query_point      = $urandom;
    queue_word(w);
  endtask

  // A query carries random entry fields, which the block must ignore.
  task automatic queue_query(input logic signed [VAL_W-1:0] point);
    plt_in_t w;
    w.func             = FUNC_QUERY;
    w.entry_index      = INDEX_W'($urandom);
    w.entry_breakpoint = BP_W'($urandom);
    w.entry_value      = $urandom;
    w.query_point      = point;
    queue_word(w);
  endtask

  // Fill entries 0..n-1 with ascending breakpoints spread over the 16-bit
  // range, with an occasional repeated breakpoint. Values are either fully
  // random or a slow walk, so both steep and gentle segments show up.
  task automatic load_ascending_table(input int n, input bit wide);
    int                      step_max, bp, k;
    logic signed [VAL_W-1:0] val;
    step_max = 65535 / n;
    bp       = -32768 + $urandom_range(0, 65535 - step_max * (n - 1));
    val      = $urandom;
    for (k = 0; k < n; k++) begin
      queue_table_write(k[INDEX_W-1:0], bp[BP_W-1:0], val);
      bp += ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, step_max);
      val = wide ? $urandom : val + $signed($urandom_range(0, 32'h1f_ffff)) - 32'sh10_0000;
    end
  endtask

  // Random words against a loaded table of n entries: mostly queries, aimed
  // at breakpoints, their neighbors and the span around the table, plus
  // writes at random entries, which for small tables mostly lie outside the used ones.
  task automatic queue_random_mix(input int n, input int count);
    int                     k, idx, sel;
    longint                 pt, lo_pt, hi_pt;
    logic signed [BP_W-1:0] bp;
    for (k = 0; k < count; k++) begin
      sel = $urandom_range(0, 9);
      if (sel >= 6) begin
        // Inside the used span a write usually changes only the value, so
        // the table stays ascending; now and then it breaks the order.
        idx = $urandom_range(0, TABLE_DEPTH - 1);
        bp  = (idx < n && $urandom_range(0, 4) != 0) ? plan_bp[idx] : BP_W'($urandom);
        queue_table_write(idx[INDEX_W-1:0], bp, $urandom);
      end else begin
        if (sel < 2) begin
          pt = longint'($signed($urandom));
        end else if (sel < 5) begin
          pt = longint'(plan_bp[$urandom_range(0, n - 1)]) * 65536;
          if (sel == 4) pt += longint'($urandom_range(0, 2)) - 1;
        end else begin
          lo_pt = longint'(plan_bp[0]) * 65536 - 64'sd1048576;
          hi_pt = longint'(plan_bp[n - 1]) * 65536 + 64'sd1048576;
          if (hi_pt <= lo_pt) hi_pt = lo_pt + 64'sd2097152;
          pt = lo_pt + longint'({$urandom, $urandom} % (hi_pt - lo_pt + 1));
        end
        if (pt > VAL_MAX) pt = VAL_MAX;
        if (pt < VAL_MIN) pt = VAL_MIN;
        queue_query(pt[VAL_W-1:0]);
      end
    end
  endtask

  // Wait until every queued word is taken and every result has come, then
  // let the block settle. A result that never comes is reported here.
  task automatic wait_idle(input int settle);
    int waited;
    @(negedge clk);
    while (items_accepted != items_pushed) @(negedge clk);
    waited = 0;
    while (expected_interp_q.size() != 0 && waited < RESULT_WAIT_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (expected_interp_q.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived",
                                expected_interp_q.size()));
      expected_interp_q.delete();
    end
    repeat (settle) @(posedge clk);
  endtask

  // The entry count is only written while the block is idle; the predictor
  // picks up the new setting at the same time.
  task automatic write_entry_count(input logic [COUNT_W-1:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en    <= 1'b0;
    shadow_count = value;
    counts_applied++;
  endtask

  // Driver. At each falling edge the current word is held until it has been
  // taken; after that the next one is offered, unless a random gap is due.
  always @(negedge clk) begin
    if (in_valid && !in_accepted) begin
      // Still waiting for the block; payload and valid stay as they are.
    end else if (src_gap_left != 0) begin
      src_gap_left--;
      in_valid <= 1'b0;
    end else if (pending_words.size() == 0) begin
      in_valid <= 1'b0;
    end else if (idle_enable && $urandom_range(0, 11) == 0) begin
      src_gap_left = $urandom_range(1, 12) - 1;
      in_valid <= 1'b0;
    end else begin
      in_data  <= pending_words.pop_front();
      in_valid <= 1'b1;
    end
  end

  // Receiver. Ready drops for random bursts, and for the whole of a long
  // hold-off when one is running.
  always @(negedge clk) begin
    if (sink_gap_left != 0) begin
      sink_gap_left--;
      out_ready <= 1'b0;
    end else if (sink_hold) begin
      out_ready <= 1'b0;
    end else if (idle_enable && $urandom_range(0, 15) == 0) begin
      sink_gap_left = $urandom_range(1, 12) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor. At each rising edge an accepted input word updates the
  // predictor's table or queues an expected result, and an accepted result
  // word is compared field by field with the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_accepted = 1'b0;
    end else begin
      in_accepted = in_valid && in_ready;
      if (in_accepted) begin
        items_accepted++;
        if (in_data.func == FUNC_WRITE) begin
          shadow_bp[in_data.entry_index]  = in_data.entry_breakpoint;
          shadow_val[in_data.entry_index] = in_data.entry_value;
          writes_taken++;
        end else begin
          expected_interp_q.push_back(predict_interp(in_data.query_point));
          queries_taken++;
        end
      end
      if (out_valid && out_ready) begin
        if (expected_interp_q.size() == 0) begin
          report_mismatch($sformatf("result word %h arrived with no query outstanding",
                                    out_data));
        end else begin
          want_word = expected_interp_q.pop_front();
          results_checked++;
          if (out_data.interp_value !== want_word.interp_value)
            report_mismatch($sformatf("interp_value %h, expected %h",
                                      out_data.interp_value, want_word.interp_value));
          if (out_data.saturated !== want_word.saturated)
            report_mismatch($sformatf("saturated %b, expected %b (interp_value %h)",
                                      out_data.saturated, want_word.saturated,
                                      want_word.interp_value));
        end
      end
    end
  end

  // Stimulus sequence.
  initial begin
    int cnt, n, phase;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part with the default two-entry table.
    write_entry_count(COUNT_W'(2));
    @(posedge clk);
    // Full-range end pair: a point on the first breakpoint, on the last,
    // beyond the last and in the middle.
    queue_table_write(9'd0, 16'sh8000, 32'sh8000_0000);
    queue_table_write(9'd1, 16'sh7fff, 32'sh7fff_ffff);
    queue_query(32'sh8000_0000);
    queue_query(32'sh7fff_0000);
    queue_query(32'sh7fff_ffff);
    queue_query(32'sh0000_0000);
    // A steep falling segment: far extrapolation clips at both ends.
    queue_table_write(9'd0, 16'sd0, 32'sh7fff_ffff);
    queue_table_write(9'd1, 16'sd1, 32'sh8000_0000);
    queue_query(32'sh8000_0000);
    queue_query(32'sh7fff_ffff);
    queue_query(32'sh0000_8000);
    // Equal breakpoints: the lower entry's value below, on and above.
    queue_table_write(9'd0, 16'sd5, 32'sd1234);
    queue_table_write(9'd1, 16'sd5, -32'sd99);
    queue_query(32'sh0004_ffff);
    queue_query(32'sh0005_0000);
    queue_query(32'sh0005_0001);
    // A descending table goes through the same scan rules.
    queue_table_write(9'd0, 16'sd10, 32'sh0001_0000);
    queue_table_write(9'd1, -16'sd10, 32'shfff0_0000);
    queue_query(32'sh0000_0000);
    queue_query(32'sh000a_0000);
    queue_query(32'shfff6_0000);
    wait_idle(SETTLE_CYCLES);

    // Full-depth table, then the same table with the count above the depth.
    write_entry_count(COUNT_W'(TABLE_DEPTH));
    @(posedge clk);
    idle_enable = 1'b1;
    load_ascending_table(TABLE_DEPTH, 1'b1);
    queue_random_mix(TABLE_DEPTH, PHASE_ITEMS);
    wait_idle(SETTLE_CYCLES);
    write_entry_count('1);
    @(posedge clk);
    queue_random_mix(TABLE_DEPTH, 16);
    wait_idle(SETTLE_CYCLES);

    // Small tables. Each phase writes a new count, loads a fresh table and
    // runs a random mix; the wait between phases leaves the sender paused
    // until every expected result is in. Counts of zero and one come first.
    phase = 0;
    while (items_pushed < TOTAL_ITEMS) begin
      case (phase)
        0:       cnt = 0;
        1:       cnt = 1;
        2:       cnt = 4;
        default: cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 64)
                                                   : $urandom_range(2, 24);
      endcase
      write_entry_count(cnt[COUNT_W-1:0]);
      @(posedge clk);
      // Some phases run without gaps, and the last stretch never has any.
      idle_enable = (items_pushed < TOTAL_ITEMS - 150) && ($urandom_range(0, 3) != 0);
      if (phase == 2) begin
        // The receiver stays off long enough for the output register and
        // a second finished query to back up into the input channel.
        fork
          begin
            @(posedge clk);
            sink_hold = 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clk);
            sink_hold = 1'b0;
          end
        join_none
      end
      n = clamp_count(cnt[COUNT_W-1:0]);
      load_ascending_table(n, 1'($urandom_range(0, 1)));
      queue_random_mix(n, PHASE_ITEMS);
      wait_idle(SETTLE_CYCLES);
      phase++;
    end

    wait_idle(FINAL_CYCLES);
    $display("Covered %0d table writes and %0d queries under %0d entry count settings,",
             writes_taken, queries_taken, counts_applied);
    $display("from below the minimum to above the table depth; %0d results checked.",
             results_checked);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin
    #30_000_000;
    $display("Timeout: the run did not reach its end");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
